[rtl/pjzc_pkg.sv]
// Package for the per-joint zero crossing counter.
// Holds the sign code, the per-joint state entry and the sample flag bundle.
// No dependencies.
package pjzc_pkg;

  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam int unsigned SampleW = 32;
  localparam int unsigned ThreshW = 31;
  localparam int unsigned JointW = 3;

  typedef enum logic [1:0] {
    SIGN_NONE = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_e;

  typedef struct packed {
    sign_e             last_sign;
    logic [CountW-1:0] crossing_count;
    logic              start_was_zero;
  } entry_t;

  typedef struct packed {
    logic first;
    logic last;
    logic nonzero;
    logic negative;
    logic below;
  } item_t;

endpackage

[rtl/pjzc_state_mem.sv]
// Per-joint state memory of the zero crossing counter.
// One write port, one read port with registered data; per-entry valid bits.
// Depends on pjzc_pkg.
module pjzc_state_mem #(
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output pjzc_pkg::entry_t    rd_data_o,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  pjzc_pkg::entry_t    wr_data_i
);

  pjzc_pkg::entry_t mem [Depth];
  logic [Depth-1:0] vld_q;
  pjzc_pkg::entry_t rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

[rtl/pjzc_update.sv]
// Update logic of the zero crossing counter: next joint state and total count.
// Combinational; fed by the registered sample flags and the joint's old state.
// Depends on pjzc_pkg.
module pjzc_update (
  input  pjzc_pkg::entry_t                  old_i,
  input  pjzc_pkg::item_t                   item_i,
  output pjzc_pkg::entry_t                  new_o,
  output logic [pjzc_pkg::CountW-1:0]       total_o
);

  pjzc_pkg::entry_t base;
  pjzc_pkg::sign_e  sgn;
  logic             end_zero;
  logic [pjzc_pkg::CountW+1:0] sum;

  always_comb begin
    if (item_i.first) begin
      base.last_sign      = pjzc_pkg::SIGN_NONE;
      base.crossing_count = '0;
      base.start_was_zero = item_i.below;
    end else begin
      base = old_i;
    end

    sgn   = item_i.negative ? pjzc_pkg::SIGN_NEG : pjzc_pkg::SIGN_POS;
    new_o = base;
    if (item_i.nonzero) begin
      if (base.last_sign != pjzc_pkg::SIGN_NONE && base.last_sign != sgn &&
          base.crossing_count != pjzc_pkg::CountMax) begin
        new_o.crossing_count = base.crossing_count + 1'b1;
      end
      new_o.last_sign = sgn;
    end

    end_zero = !item_i.first && item_i.below;
    sum = (pjzc_pkg::CountW+2)'(new_o.crossing_count) +
          (pjzc_pkg::CountW+2)'(new_o.start_was_zero) +
          (pjzc_pkg::CountW+2)'(end_zero);
    if (sum > (pjzc_pkg::CountW+2)'(pjzc_pkg::CountMax)) begin
      total_o = pjzc_pkg::CountMax;
    end else begin
      total_o = sum[pjzc_pkg::CountW-1:0];
    end
  end

endmodule

[rtl/per_joint_zero_crossing_counter_unit.sv]
// Top level of the per-joint zero crossing counter.
// Instantiates pjzc_state_mem and pjzc_update; uses pjzc_pkg.
//
//   Channel  Handshake                  Payload
//   cfg      cfg_valid_i / cfg_ready_o  cfg_zero_threshold_i
//   in       in_valid_i / in_ready_o    joint_i, sample_value_i, first_sample_i, last_sample_i
//   out      out_valid_o / out_ready_i  joint_out_o, inner_crossings_o, total_crossings_o
//
// One sample is taken every cycle unless input is stalled; a result passes stage 1 and the
// output register. The state memory is read on acceptance and written back as the sample
// leaves stage 1, with forwarding when consecutive samples hit the same joint.
// Reset clears the per-joint valid bits at once, so no clearing pass is needed.
// A stalled result in the output register stalls input only when the next result is ready.
module per_joint_zero_crossing_counter_unit #(
  parameter int unsigned MAX_JOINTS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pjzc_pkg::ThreshW-1:0]         cfg_zero_threshold_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [pjzc_pkg::JointW-1:0]          joint_i,
  input  logic signed [pjzc_pkg::SampleW-1:0]  sample_value_i,
  input  logic                                 first_sample_i,
  input  logic                                 last_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [pjzc_pkg::JointW-1:0]          joint_out_o,
  output logic [pjzc_pkg::CountW-1:0]          inner_crossings_o,
  output logic [pjzc_pkg::CountW-1:0]          total_crossings_o
);

  localparam int unsigned AddrW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  logic [pjzc_pkg::ThreshW-1:0]  thr_q;
  logic [AddrW+pjzc_pkg::JointW-1:0] joint_ext;
  logic [AddrW-1:0]              in_addr;
  logic                          in_range;
  logic                          accept;
  logic [pjzc_pkg::SampleW-1:0]  raw;
  logic [pjzc_pkg::SampleW-1:0]  mag;
  pjzc_pkg::item_t               in_item;

  logic                          s1_valid_q;
  pjzc_pkg::item_t               s1_item_q;
  logic [AddrW-1:0]              s1_addr_q;
  logic [pjzc_pkg::JointW-1:0]   s1_joint_q;
  logic                          fwd_hit_q;
  pjzc_pkg::entry_t              fwd_data_q;
  logic                          s1_stall;
  logic                          s1_fire;

  pjzc_pkg::entry_t              rd_data;
  pjzc_pkg::entry_t              old_state;
  pjzc_pkg::entry_t              new_state;
  logic [pjzc_pkg::CountW-1:0]   total;

  logic                          out_valid_q;
  logic [pjzc_pkg::JointW-1:0]   out_joint_q;
  logic [pjzc_pkg::CountW-1:0]   out_inner_q;
  logic [pjzc_pkg::CountW-1:0]   out_total_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_zero_threshold_i;
    end
  end

  assign joint_ext = {{AddrW{1'b0}}, joint_i};
  assign in_addr   = joint_ext[AddrW-1:0];
  assign in_range  = 32'(joint_i) < 32'(MAX_JOINTS);

  assign raw = $unsigned(sample_value_i);
  assign mag = raw[pjzc_pkg::SampleW-1] ? (~raw + 1'b1) : raw;

  always_comb begin
    in_item.first    = first_sample_i;
    in_item.last     = last_sample_i;
    in_item.nonzero  = raw != '0;
    in_item.negative = raw[pjzc_pkg::SampleW-1];
    in_item.below    = mag < {1'b0, thr_q};
  end

  assign s1_stall   = s1_valid_q && s1_item_q.last && out_valid_q && !out_ready_i;
  assign s1_fire    = s1_valid_q && !s1_stall;
  assign in_ready_o = !s1_stall;
  assign accept     = in_valid_i && in_ready_o;

  pjzc_state_mem #(
    .Depth (MAX_JOINTS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && in_range),
    .rd_addr_i (in_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (new_state)
  );

  assign old_state = fwd_hit_q ? fwd_data_q : rd_data;

  pjzc_update u_update (
    .old_i   (old_state),
    .item_i  (s1_item_q),
    .new_o   (new_state),
    .total_o (total)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= in_range;
      fwd_hit_q  <= s1_fire && (s1_addr_q == in_addr);
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q  <= in_item;
      s1_addr_q  <= in_addr;
      s1_joint_q <= joint_i;
      fwd_data_q <= new_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_item_q.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_item_q.last) begin
      out_joint_q <= s1_joint_q;
      out_inner_q <= new_state.crossing_count;
      out_total_q <= total;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign joint_out_o       = out_joint_q;
  assign inner_crossings_o = out_inner_q;
  assign total_crossings_o = out_total_q;

endmodule

[rtl/pjzc_checker.sv]
// Port-level checks for the per-joint zero crossing counter.
// Bound to per_joint_zero_crossing_counter_unit; uses pjzc_pkg for widths.
module pjzc_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic [pjzc_pkg::JointW-1:0]          joint_i,
  input logic                                 last_sample_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [pjzc_pkg::JointW-1:0]          joint_out_o,
  input logic [pjzc_pkg::CountW-1:0]          inner_crossings_o,
  input logic [pjzc_pkg::CountW-1:0]          total_crossings_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(joint_out_o) &&
    $stable(inner_crossings_o) && $stable(total_crossings_o))
    else $error("Result changed while stalled.");

  a_total_ge_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> total_crossings_o >= inner_crossings_o)
    else $error("Total count below inner count.");

  a_total_near_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      {1'b0, total_crossings_o} <= {1'b0, inner_crossings_o} + 17'd2)
    else $error("Total count exceeds inner count by more than two.");

  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && in_ready_o && last_sample_i, 2) &&
      joint_out_o == $past(joint_i, 2))
    else $error("Result without a matching last sample request.");

endmodule

bind per_joint_zero_crossing_counter_unit pjzc_checker u_pjzc_checker (.*);
